>>> rtl/ptw_pkg.sv
// Shared types, constants and codes of the four-level page table walk unit.
package ptw_pkg;

  localparam int POOL_PAGES  = 16;
  localparam int PAGE_W      = $clog2(POOL_PAGES);
  localparam int IDX_W       = 9;
  localparam int STORE_AW    = PAGE_W + IDX_W;
  localparam int STORE_DEPTH = POOL_PAGES * 512;
  localparam int CNT_W       = $clog2(POOL_PAGES + 1);
  localparam int FREE_RESET  = POOL_PAGES - 3;
  localparam int ENTRY_W     = 52;
  localparam int VA_W        = 48;
  localparam int PA_W        = 52;
  localparam int FRAME_W     = PA_W - 12;
  localparam int APB_AW      = 4;
  localparam int APB_DW      = 64;

  localparam logic [2:0] LINK_FLAGS = 3'b111;

  localparam logic [STORE_AW-1:0] PRESET0_ADDR = STORE_AW'(0);
  localparam logic [STORE_AW-1:0] PRESET1_ADDR = STORE_AW'((1 << IDX_W) | 3);
  localparam logic [ENTRY_W-1:0]  PRESET0_DATA = ENTRY_W'((1 << 12) | 7);
  localparam logic [ENTRY_W-1:0]  PRESET1_DATA = ENTRY_W'((2 << 12) | 7);

  // Register select is address bit 3 (registers sit 8 bytes apart).
  localparam logic REG_TABLE_BASE   = 1'b0;
  localparam logic REG_TABLE_ACTIVE = 1'b1;

  typedef enum logic [1:0] {
    CMD_TRANSLATE = 2'd0,
    CMD_MAP       = 2'd1,
    CMD_UNMAP     = 2'd2,
    CMD_NONE      = 2'd3
  } command_t;

  typedef enum logic [2:0] {
    ST_OK          = 3'd0,
    ST_NOT_PRESENT = 3'd1,
    ST_NO_FREE     = 3'd2,
    ST_MAPPED      = 3'd3,
    ST_WRONG_SIZE  = 3'd4
  } status_t;

  typedef enum logic [3:0] {
    S_CLEAR, S_PRE0, S_PRE1, S_IDLE, S_READ, S_EVAL,
    S_ZERO, S_LINK, S_SCAN, S_SCHK, S_UPZ, S_DONE
  } state_t;

  typedef enum logic [2:0] {
    AS_WALK, AS_CLEAR, AS_NEWPG, AS_SCAN, AS_PRE0, AS_PRE1
  } asel_t;

  typedef enum logic [2:0] {
    WD_ZERO, WD_LINK, WD_LEAF, WD_PRE0, WD_PRE1
  } wsel_t;

  typedef struct packed {
    logic [1:0]      command;
    logic [VA_W-1:0] virtual_address;
    logic [PA_W-1:0] physical_address;
    logic            superpage;
    logic            global_page;
    logic            writable;
    logic            user_access;
  } req_t;

  typedef struct packed {
    logic [2:0]      status;
    logic [PA_W-1:0] frame_address;
    logic            invalidate;
    logic [VA_W-1:0] invalidate_address;
  } rsp_t;

  typedef struct packed {
    logic    load_item;
    asel_t   asel;
    logic    we;
    wsel_t   wsel;
    logic    re;
    logic    cnt_clr;
    logic    cnt_inc;
    logic    lvl_dec;
    logic    lvl_inc;
    logic    descend;
    logic    pop;
    logic    push;
    logic    res_load;
    status_t res_status;
  } ctrl_t;

  typedef struct packed {
    logic       present;
    logic       huge;
    logic       link_ok;
    logic [1:0] lvl;
    logic [1:0] cmd;
    logic       big;
    logic       stack_empty;
    logic       clear_last;
    logic       page_last;
    logic       nonempty;
  } stat_t;

endpackage

>>> rtl/ptw_ram.sv
// Generic single-port RAM with registered read data.
module ptw_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic                     we,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    if (re) begin
      rdata <= mem[addr];
    end
  end

endmodule

>>> rtl/ptw_dp.sv
// Datapath: item registers, entry store, free page stack, link decode and result.
module ptw_dp (
  input  logic                         clk,
  input  logic                         rst,
  input  ptw_pkg::ctrl_t               ctl,
  input  ptw_pkg::req_t                req,
  input  logic [ptw_pkg::PA_W-1:0]     table_base,
  input  logic                         table_active,
  output ptw_pkg::stat_t               st,
  output ptw_pkg::rsp_t                result
);

  logic [1:0]                     cmd;
  logic [ptw_pkg::VA_W-1:0]       va;
  logic [ptw_pkg::PA_W-1:0]       pa;
  logic                           big;
  logic                           gflag;
  logic                           wflag;
  logic                           uflag;
  logic [1:0]                     lvl;
  logic [ptw_pkg::PAGE_W-1:0]     pg [4];
  logic [ptw_pkg::PAGE_W-1:0]     new_pg;
  logic [ptw_pkg::STORE_AW-1:0]   cnt;
  logic                           acc;
  logic                           scan_rv;
  logic [ptw_pkg::PAGE_W-1:0]     stack [ptw_pkg::POOL_PAGES];
  logic [ptw_pkg::CNT_W-1:0]      count;

  logic [ptw_pkg::STORE_AW-1:0]   addr;
  logic [ptw_pkg::ENTRY_W-1:0]    wdata;
  logic [ptw_pkg::ENTRY_W-1:0]    rdata;
  logic [ptw_pkg::IDX_W-1:0]      idx;
  logic [ptw_pkg::PAGE_W-1:0]     cur_pg;
  logic [ptw_pkg::FRAME_W-1:0]    off;
  logic [ptw_pkg::PAGE_W-1:0]     top_pg;
  logic [ptw_pkg::PA_W-1:0]       pa_al;
  logic [ptw_pkg::PA_W-1:0]       frame;
  logic [ptw_pkg::VA_W-1:0]       va_al;
  logic [1:0]                     lvl_dn;

  assign cur_pg = pg[lvl];
  assign lvl_dn = lvl - 2'd1;
  assign top_pg = stack[ptw_pkg::PAGE_W'(count - 1'b1)];

  always_comb begin
    case (lvl)
      2'd3:    idx = va[47:39];
      2'd2:    idx = va[38:30];
      2'd1:    idx = va[29:21];
      default: idx = va[20:12];
    endcase
  end

  // A link counts only when it points inside the table page pool.
  assign off = rdata[ptw_pkg::PA_W-1:12] - table_base[ptw_pkg::PA_W-1:12];

  always_comb begin
    case (ctl.asel)
      ptw_pkg::AS_WALK:  addr = {cur_pg, idx};
      ptw_pkg::AS_CLEAR: addr = cnt;
      ptw_pkg::AS_NEWPG: addr = {new_pg, cnt[ptw_pkg::IDX_W-1:0]};
      ptw_pkg::AS_SCAN:  addr = {cur_pg, cnt[ptw_pkg::IDX_W-1:0]};
      ptw_pkg::AS_PRE0:  addr = ptw_pkg::PRESET0_ADDR;
      ptw_pkg::AS_PRE1:  addr = ptw_pkg::PRESET1_ADDR;
      default:           addr = ptw_pkg::PRESET0_ADDR;
    endcase
  end

  assign pa_al = big ? {pa[ptw_pkg::PA_W-1:21], 21'd0} : {pa[ptw_pkg::PA_W-1:12], 12'd0};
  assign va_al = big ? {va[ptw_pkg::VA_W-1:21], 21'd0} : {va[ptw_pkg::VA_W-1:12], 12'd0};

  always_comb begin
    case (ctl.wsel)
      ptw_pkg::WD_LINK: wdata = {table_base[ptw_pkg::PA_W-1:12] +
                                 ptw_pkg::FRAME_W'(new_pg), 9'd0, ptw_pkg::LINK_FLAGS};
      ptw_pkg::WD_LEAF: wdata = pa_al | {43'd0, gflag, big, 4'd0, uflag, wflag, 1'b1};
      ptw_pkg::WD_PRE0: wdata = ptw_pkg::PRESET0_DATA;
      ptw_pkg::WD_PRE1: wdata = ptw_pkg::PRESET1_DATA;
      default:          wdata = '0;
    endcase
  end

  always_comb begin
    case (lvl)
      2'd2:    frame = {rdata[ptw_pkg::PA_W-1:30], 30'd0};
      2'd1:    frame = {rdata[ptw_pkg::PA_W-1:21], 21'd0};
      default: frame = {rdata[ptw_pkg::PA_W-1:12], 12'd0};
    endcase
  end

  ptw_ram #(
    .WIDTH(ptw_pkg::ENTRY_W),
    .DEPTH(ptw_pkg::STORE_DEPTH)
  ) u_store (
    .clk  (clk),
    .addr (addr),
    .we   (ctl.we),
    .wdata(wdata),
    .re   (ctl.re),
    .rdata(rdata)
  );

  always_ff @(posedge clk) begin
    if (ctl.load_item) begin
      cmd   <= req.command;
      va    <= req.virtual_address;
      pa    <= req.physical_address;
      big   <= req.superpage;
      gflag <= req.global_page;
      wflag <= req.writable;
      uflag <= req.user_access;
      pg[3] <= '0;
    end
    if (ctl.descend) begin
      pg[lvl_dn] <= off[ptw_pkg::PAGE_W-1:0];
    end
    if (ctl.pop) begin
      pg[lvl_dn] <= top_pg;
      new_pg     <= top_pg;
    end
    if (ctl.push && count < ptw_pkg::CNT_W'(ptw_pkg::POOL_PAGES)) begin
      stack[ptw_pkg::PAGE_W'(count)] <= cur_pg;
    end
    if (ctl.res_load) begin
      result.status <= ctl.res_status;
      result.frame_address <= (cmd == ptw_pkg::CMD_TRANSLATE &&
                               ctl.res_status == ptw_pkg::ST_OK) ? frame : '0;
      result.invalidate <= (cmd == ptw_pkg::CMD_MAP || cmd == ptw_pkg::CMD_UNMAP) &&
                           ctl.res_status == ptw_pkg::ST_OK && table_active;
      result.invalidate_address <= ((cmd == ptw_pkg::CMD_MAP || cmd == ptw_pkg::CMD_UNMAP)
                                    && ctl.res_status == ptw_pkg::ST_OK && table_active)
                                   ? va_al : '0;
    end
    if (rst) begin
      for (int i = 0; i < ptw_pkg::POOL_PAGES; i++) begin
        stack[i] <= ptw_pkg::PAGE_W'(i + 3);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      lvl     <= 2'd3;
      cnt     <= '0;
      acc     <= 1'b0;
      scan_rv <= 1'b0;
      count   <= ptw_pkg::CNT_W'(ptw_pkg::FREE_RESET);
    end else begin
      scan_rv <= ctl.re && ctl.asel == ptw_pkg::AS_SCAN;
      if (ctl.load_item) begin
        lvl <= 2'd3;
      end else if (ctl.lvl_dec) begin
        lvl <= lvl_dn;
      end else if (ctl.lvl_inc) begin
        lvl <= lvl + 2'd1;
      end
      if (ctl.cnt_clr) begin
        cnt <= '0;
        acc <= 1'b0;
      end else begin
        if (ctl.cnt_inc) begin
          cnt <= cnt + 1'b1;
        end
        acc <= acc | (scan_rv & rdata[0]);
      end
      if (ctl.pop) begin
        count <= count - 1'b1;
      end else if (ctl.push && count < ptw_pkg::CNT_W'(ptw_pkg::POOL_PAGES)) begin
        count <= count + 1'b1;
      end
    end
  end

  assign st.present     = rdata[0];
  assign st.huge        = rdata[7];
  assign st.link_ok     = off < ptw_pkg::FRAME_W'(ptw_pkg::POOL_PAGES);
  assign st.lvl         = lvl;
  assign st.cmd         = cmd;
  assign st.big         = big;
  assign st.stack_empty = count == '0;
  assign st.clear_last  = cnt == ptw_pkg::STORE_AW'(ptw_pkg::STORE_DEPTH - 1);
  assign st.page_last   = cnt[ptw_pkg::IDX_W-1:0] == '1;
  assign st.nonempty    = acc | (scan_rv & rdata[0]);

  a_pop_nonempty: assert property (@(posedge clk) disable iff (rst)
    ctl.pop |-> count != '0) else $error("pop from an empty free page stack");
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= ptw_pkg::CNT_W'(ptw_pkg::POOL_PAGES)) else $error("free page count overflow");
  a_port_conflict: assert property (@(posedge clk) disable iff (rst)
    !(ctl.we && ctl.re)) else $error("entry store read and written in one cycle");

endmodule

>>> rtl/ptw_ctrl.sv
// Controller state machine that sequences the table walk, page clearing and unmap scans.
module ptw_ctrl (
  input  logic            clk,
  input  logic            rst,
  input  logic            accept,
  input  logic            out_free,
  input  ptw_pkg::stat_t  st,
  output ptw_pkg::ctrl_t  ctl,
  output logic            idle,
  output logic            out_load
);

  ptw_pkg::state_t state;
  ptw_pkg::state_t state_next;
  logic            leaf;
  logic            mid;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ptw_pkg::S_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  // The leaf sits one level higher for a 2 MiB page.
  assign leaf = st.lvl == (st.big ? 2'd1 : 2'd0);
  assign mid  = st.lvl == 2'd1 || st.lvl == 2'd2;

  always_comb begin
    state_next = state;
    ctl        = '0;
    idle       = 1'b0;
    out_load   = 1'b0;
    case (state)
      ptw_pkg::S_CLEAR: begin
        ctl.asel    = ptw_pkg::AS_CLEAR;
        ctl.we      = 1'b1;
        ctl.wsel    = ptw_pkg::WD_ZERO;
        ctl.cnt_inc = 1'b1;
        if (st.clear_last) begin
          state_next = ptw_pkg::S_PRE0;
        end
      end
      ptw_pkg::S_PRE0: begin
        ctl.asel   = ptw_pkg::AS_PRE0;
        ctl.we     = 1'b1;
        ctl.wsel   = ptw_pkg::WD_PRE0;
        state_next = ptw_pkg::S_PRE1;
      end
      ptw_pkg::S_PRE1: begin
        ctl.asel   = ptw_pkg::AS_PRE1;
        ctl.we     = 1'b1;
        ctl.wsel   = ptw_pkg::WD_PRE1;
        state_next = ptw_pkg::S_IDLE;
      end
      ptw_pkg::S_IDLE: begin
        idle = 1'b1;
        if (accept) begin
          ctl.load_item = 1'b1;
          state_next    = ptw_pkg::S_READ;
        end
      end
      ptw_pkg::S_READ: begin
        if (st.cmd == ptw_pkg::CMD_NONE) begin
          ctl.res_load   = 1'b1;
          ctl.res_status = ptw_pkg::ST_NOT_PRESENT;
          state_next     = ptw_pkg::S_DONE;
        end else begin
          ctl.asel   = ptw_pkg::AS_WALK;
          ctl.re     = 1'b1;
          state_next = ptw_pkg::S_EVAL;
        end
      end
      ptw_pkg::S_EVAL: begin
        ctl.asel   = ptw_pkg::AS_WALK;
        state_next = ptw_pkg::S_DONE;
        case (st.cmd)
          ptw_pkg::CMD_TRANSLATE: begin
            if (!st.present) begin
              ctl.res_load   = 1'b1;
              ctl.res_status = ptw_pkg::ST_NOT_PRESENT;
            end else if (st.lvl == 2'd0 || (st.huge && mid)) begin
              ctl.res_load   = 1'b1;
              ctl.res_status = ptw_pkg::ST_OK;
            end else if (!st.link_ok) begin
              ctl.res_load   = 1'b1;
              ctl.res_status = ptw_pkg::ST_NOT_PRESENT;
            end else begin
              ctl.descend = 1'b1;
              ctl.lvl_dec = 1'b1;
              state_next  = ptw_pkg::S_READ;
            end
          end
          ptw_pkg::CMD_MAP: begin
            if (leaf) begin
              ctl.res_load = 1'b1;
              if (st.present) begin
                ctl.res_status = ptw_pkg::ST_MAPPED;
              end else begin
                ctl.we         = 1'b1;
                ctl.wsel       = ptw_pkg::WD_LEAF;
                ctl.res_status = ptw_pkg::ST_OK;
              end
            end else if (st.present && st.huge && mid) begin
              ctl.res_load   = 1'b1;
              ctl.res_status = ptw_pkg::ST_MAPPED;
            end else if (st.present) begin
              if (st.link_ok) begin
                ctl.descend = 1'b1;
                ctl.lvl_dec = 1'b1;
                state_next  = ptw_pkg::S_READ;
              end else begin
                ctl.res_load   = 1'b1;
                ctl.res_status = ptw_pkg::ST_NO_FREE;
              end
            end else if (st.stack_empty) begin
              ctl.res_load   = 1'b1;
              ctl.res_status = ptw_pkg::ST_NO_FREE;
            end else begin
              ctl.pop     = 1'b1;
              ctl.cnt_clr = 1'b1;
              state_next  = ptw_pkg::S_ZERO;
            end
          end
          ptw_pkg::CMD_UNMAP: begin
            if (!st.present) begin
              ctl.res_load   = 1'b1;
              ctl.res_status = ptw_pkg::ST_NOT_PRESENT;
            end else if (leaf) begin
              if (st.lvl == 2'd1 && !st.huge) begin
                ctl.res_load   = 1'b1;
                ctl.res_status = ptw_pkg::ST_WRONG_SIZE;
              end else begin
                ctl.we      = 1'b1;
                ctl.wsel    = ptw_pkg::WD_ZERO;
                ctl.cnt_clr = 1'b1;
                state_next  = ptw_pkg::S_SCAN;
              end
            end else if (mid && st.huge) begin
              ctl.res_load   = 1'b1;
              ctl.res_status = ptw_pkg::ST_WRONG_SIZE;
            end else if (!st.link_ok) begin
              ctl.res_load   = 1'b1;
              ctl.res_status = ptw_pkg::ST_NOT_PRESENT;
            end else begin
              ctl.descend = 1'b1;
              ctl.lvl_dec = 1'b1;
              state_next  = ptw_pkg::S_READ;
            end
          end
          default: begin
            ctl.res_load   = 1'b1;
            ctl.res_status = ptw_pkg::ST_NOT_PRESENT;
          end
        endcase
      end
      ptw_pkg::S_ZERO: begin
        ctl.asel    = ptw_pkg::AS_NEWPG;
        ctl.we      = 1'b1;
        ctl.wsel    = ptw_pkg::WD_ZERO;
        ctl.cnt_inc = 1'b1;
        if (st.page_last) begin
          state_next = ptw_pkg::S_LINK;
        end
      end
      ptw_pkg::S_LINK: begin
        ctl.asel    = ptw_pkg::AS_WALK;
        ctl.we      = 1'b1;
        ctl.wsel    = ptw_pkg::WD_LINK;
        ctl.lvl_dec = 1'b1;
        state_next  = ptw_pkg::S_READ;
      end
      ptw_pkg::S_SCAN: begin
        ctl.asel    = ptw_pkg::AS_SCAN;
        ctl.re      = 1'b1;
        ctl.cnt_inc = 1'b1;
        if (st.page_last) begin
          state_next = ptw_pkg::S_SCHK;
        end
      end
      ptw_pkg::S_SCHK: begin
        if (st.nonempty) begin
          ctl.res_load   = 1'b1;
          ctl.res_status = ptw_pkg::ST_OK;
          state_next     = ptw_pkg::S_DONE;
        end else begin
          ctl.push    = 1'b1;
          ctl.lvl_inc = 1'b1;
          state_next  = ptw_pkg::S_UPZ;
        end
      end
      ptw_pkg::S_UPZ: begin
        // Drop the link to the page just freed; the root page is never freed.
        ctl.asel = ptw_pkg::AS_WALK;
        ctl.we   = 1'b1;
        ctl.wsel = ptw_pkg::WD_ZERO;
        if (st.lvl == 2'd3) begin
          ctl.res_load   = 1'b1;
          ctl.res_status = ptw_pkg::ST_OK;
          state_next     = ptw_pkg::S_DONE;
        end else begin
          ctl.cnt_clr = 1'b1;
          state_next  = ptw_pkg::S_SCAN;
        end
      end
      ptw_pkg::S_DONE: begin
        if (out_free) begin
          out_load   = 1'b1;
          state_next = ptw_pkg::S_IDLE;
        end
      end
      default: begin
        state_next = ptw_pkg::S_IDLE;
      end
    endcase
  end

  a_alloc_map_only: assert property (@(posedge clk) disable iff (rst)
    (state == ptw_pkg::S_ZERO || state == ptw_pkg::S_LINK) |-> st.cmd == ptw_pkg::CMD_MAP)
    else $error("table page allocated outside a map");
  a_scan_unmap_only: assert property (@(posedge clk) disable iff (rst)
    state == ptw_pkg::S_SCAN |-> st.cmd == ptw_pkg::CMD_UNMAP && st.lvl != 2'd3)
    else $error("page scan outside an unmap or on the root");
  a_done_holds: assert property (@(posedge clk) disable iff (rst)
    (state == ptw_pkg::S_DONE && !out_free) |=> state == ptw_pkg::S_DONE)
    else $error("finished item left before the output stage was free");

endmodule

>>> rtl/page_table_map_unmap_walk_unit.sv
// Top level of the four-level page table walk unit: config registers, output register.
//
//  channel | direction | handshake             | beat
//  req     | in        | req_valid/req_ready   | req_t: command, addresses, flags
//  rsp     | out       | rsp_valid/rsp_ready   | rsp_t: status, frame, invalidation
//  apb     | in        | psel/penable/pready   | table_base (0x0), table_active (0x8)
//
// One item at a time. Each table level is a read and then a decision. A map also clears each
// directory page it allocates (writing 512 entries over the single store port) and then writes
// the link; an unmap reads every entry of each page it scans and writes one more entry per
// page it frees.
// After reset the store is cleared one entry a cycle while req_ready is low.
// A beat that waits on rsp_ready holds the next item in the output stage only.
module page_table_map_unmap_walk_unit (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           req_valid,
  output logic                           req_ready,
  input  ptw_pkg::req_t                  req,
  output logic                           rsp_valid,
  input  logic                           rsp_ready,
  output ptw_pkg::rsp_t                  rsp,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [ptw_pkg::APB_AW-1:0]     paddr,
  input  logic [ptw_pkg::APB_DW-1:0]     pwdata,
  output logic [ptw_pkg::APB_DW-1:0]     prdata,
  output logic                           pready
);

  logic [ptw_pkg::PA_W-1:0] table_base;
  logic                     table_active;
  ptw_pkg::ctrl_t           ctl;
  ptw_pkg::stat_t           st;
  ptw_pkg::rsp_t            result;
  logic                     idle;
  logic                     out_load;
  logic                     out_free;
  logic                     wr;

  assign pready = 1'b1;
  assign wr     = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      table_base   <= '0;
      table_active <= 1'b1;
    end else if (wr) begin
      case (paddr[3])
        ptw_pkg::REG_TABLE_BASE:   table_base   <= pwdata[ptw_pkg::PA_W-1:0];
        ptw_pkg::REG_TABLE_ACTIVE: table_active <= pwdata[0];
        default:                   table_active <= table_active;
      endcase
    end
  end

  always_comb begin
    case (paddr[3])
      ptw_pkg::REG_TABLE_BASE:   prdata = ptw_pkg::APB_DW'(table_base);
      ptw_pkg::REG_TABLE_ACTIVE: prdata = ptw_pkg::APB_DW'(table_active);
      default:                   prdata = '0;
    endcase
  end

  assign req_ready = idle;
  assign out_free  = !rsp_valid || rsp_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (out_load) begin
      rsp_valid <= 1'b1;
    end else if (rsp_ready) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      rsp <= result;
    end
  end

  ptw_ctrl u_ctrl (
    .clk     (clk),
    .rst     (rst),
    .accept  (req_valid && req_ready),
    .out_free(out_free),
    .st      (st),
    .ctl     (ctl),
    .idle    (idle),
    .out_load(out_load)
  );

  ptw_dp u_dp (
    .clk         (clk),
    .rst         (rst),
    .ctl         (ctl),
    .req         (req),
    .table_base  (table_base),
    .table_active(table_active),
    .st          (st),
    .result      (result)
  );

endmodule
